/* hdl/knn_manhattan_classifier_defines.svh */
// Assertion macros shared by the checker.
`ifndef KNN_MANHATTAN_CLASSIFIER_DEFINES_SVH
`define KNN_MANHATTAN_CLASSIFIER_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define KNN_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define KNN_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* hdl/knn_pkg.sv */
`timescale 1ns / 1ps
package knn_pkg;
    localparam int MAX_SAMPLES    = 1024;
    localparam int MAX_NEIGHBOURS = 32;
    localparam int IDX_W  = $clog2(MAX_SAMPLES);
    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int K_W    = 6;
    localparam int BIDX_W = $clog2(MAX_NEIGHBOURS);
    localparam int DIST_W = 18;
    localparam int SUM_W  = 16 + K_W;
    localparam logic [K_W-1:0] K_RESET = 6'd3;

    localparam logic [1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [1:0] FUNC_LOAD   = 2'd1;
    localparam logic [1:0] FUNC_QUERY  = 2'd2;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    localparam logic [1:0] CLASS_VIRGINICA  = 2'd0;
    localparam logic [1:0] CLASS_VERSICOLOR = 2'd1;
    localparam logic [1:0] CLASS_SETOSA     = 2'd2;
    localparam logic [1:0] CLASS_OTHER      = 2'd3;

    typedef struct packed {
        logic [1:0]  class_code;
        logic [15:0] attr_petal_wid;
        logic [15:0] attr_petal_len;
        logic [15:0] attr_sepal_wid;
        logic [15:0] attr_sepal_len;
        logic [1:0]  func;
    } knn_in_t;

    typedef struct packed {
        logic [1:0]  majority_class;
        logic [5:0]  count_setosa;
        logic [5:0]  count_versicolor;
        logic [5:0]  count_virginica;
        logic [15:0] mean_petal_wid;
        logic [15:0] mean_petal_len;
        logic [15:0] mean_sepal_wid;
        logic [15:0] mean_sepal_len;
    } knn_out_t;

    // Start request and divisor from the sequencer to the divider.
    typedef struct packed {
        logic             start;
        logic [K_W-1:0]   divisor;
    } knn_div_ctl_t;

    function automatic logic [15:0] knn_absdiff(input logic [15:0] a, input logic [15:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction
endpackage

/* hdl/knn_ram.sv */
`timescale 1ns / 1ps
module knn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* hdl/knn_div.sv */
`timescale 1ns / 1ps
// Restoring divider for the four attribute sums, one quotient bit per cycle.
module knn_div import knn_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  knn_div_ctl_t        ctl,
    input  logic [SUM_W-1:0]    dividend [4],
    output logic [15:0]         quotient [4],
    output logic                done
);
    localparam int STEPS = SUM_W;
    logic [SUM_W-1:0] q_reg [4];
    logic [K_W:0]     r_reg [4];
    logic [K_W-1:0]   d_reg;
    logic [$clog2(STEPS+1)-1:0] cnt_reg;
    logic             busy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done <= 1'b0;
            if (ctl.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                d_reg    <= ctl.divisor;
                for (int a = 0; a < 4; a++) begin
                    q_reg[a] <= dividend[a];
                    r_reg[a] <= '0;
                end
            end else if (busy_reg) begin
                for (int a = 0; a < 4; a++) begin
                    logic [K_W:0] t;
                    t = {r_reg[a][K_W-1:0], q_reg[a][SUM_W-1]};
                    if (t >= {1'b0, d_reg}) begin
                        r_reg[a] <= t - {1'b0, d_reg};
                        q_reg[a] <= {q_reg[a][SUM_W-2:0], 1'b1};
                    end else begin
                        r_reg[a] <= t;
                        q_reg[a] <= {q_reg[a][SUM_W-2:0], 1'b0};
                    end
                end
                if (cnt_reg == ($clog2(STEPS+1))'(STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end
    always_comb begin
        for (int a = 0; a < 4; a++) quotient[a] = q_reg[a][15:0];
    end
endmodule

/* hdl/knn_engine.sv */
`timescale 1ns / 1ps
// Sequencer: loads and clears the sample store; a query scans with a sorted best list, then gathers and divides.
module knn_engine import knn_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic [K_W-1:0]  k_cfg,
    input  logic            s_valid,
    output logic            s_ready,
    input  knn_in_t         s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output knn_out_t        m_data
);
    typedef enum logic [2:0] {
        ST_IDLE, ST_SCAN, ST_GATHER, ST_DIVIDE, ST_OUT
    } state_t;

    state_t state_reg;
    logic [CNT_W-1:0] stored_reg;
    logic [63:0] q_reg;
    logic [K_W-1:0] k_reg, used_reg;
    logic [CNT_W-1:0] scan_reg;         // address issued
    logic             rd_v_reg;          // read data valid for index rd_i_reg
    logic [IDX_W-1:0] rd_i_reg;
    logic [DIST_W-1:0] bd_reg [MAX_NEIGHBOURS];
    logic [IDX_W-1:0]  bi_reg [MAX_NEIGHBOURS];
    logic [K_W-1:0]    g_reg;
    logic              g_v_reg;
    logic [SUM_W-1:0]  sum_reg [4];
    logic [5:0]        cnt_reg [3];
    logic [15:0]       quo [4];
    logic              div_done;
    knn_div_ctl_t      div_ctl;

    logic              we;
    logic [IDX_W-1:0]  raddr;
    logic [65:0]       rdata;

    knn_ram #(.WIDTH(66), .DEPTH(MAX_SAMPLES)) u_store (
        .aclk(aclk), .we(we), .waddr(stored_reg[IDX_W-1:0]),
        .wdata({s_data.class_code, s_data.attr_petal_wid, s_data.attr_petal_len,
                s_data.attr_sepal_wid, s_data.attr_sepal_len}),
        .raddr(raddr), .rdata(rdata)
    );

    knn_div u_div (
        .aclk(aclk), .aresetn(aresetn), .ctl(div_ctl),
        .dividend(sum_reg), .quotient(quo), .done(div_done)
    );

    assign s_ready = (state_reg == ST_IDLE);
    wire acc = s_valid && s_ready;
    assign we = acc && s_data.func == FUNC_LOAD && stored_reg < CNT_W'(MAX_SAMPLES);
    assign raddr = (state_reg == ST_GATHER) ? bi_reg[g_reg[BIDX_W-1:0]]
                                            : scan_reg[IDX_W-1:0];

    // Distance of the sample on the read port.
    logic [DIST_W-1:0] dist_sum;
    always_comb begin
        dist_sum = '0;
        for (int a = 0; a < 4; a++)
            dist_sum = dist_sum + DIST_W'(knn_absdiff(rdata[16*a +: 16], q_reg[16*a +: 16]));
    end

    // Insertion: every slot compares with the new distance in parallel.
    logic [K_W-1:0] used_next;
    logic           ins;
    always_comb begin
        ins = 1'b0;
        if (used_reg < k_reg) ins = 1'b1;
        else if (k_reg != '0 && dist_sum < bd_reg[BIDX_W'(k_reg - 1'b1)]) ins = 1'b1;
        used_next = (used_reg < k_reg) ? used_reg + 1'b1 : used_reg;
    end

    logic [K_W-1:0] kc;
    always_comb begin
        kc = (k_cfg == '0) ? K_W'(1) : k_cfg;
        if (kc > K_W'(MAX_NEIGHBOURS)) kc = K_W'(MAX_NEIGHBOURS);
        if (CNT_W'(kc) > stored_reg) kc = K_W'(stored_reg);
    end

    always_comb begin
        div_ctl.start   = (state_reg == ST_GATHER) && !g_v_reg && g_reg == used_reg
                          && used_reg != '0;
        div_ctl.divisor = used_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            stored_reg <= '0;
            m_valid    <= 1'b0;
            rd_v_reg   <= 1'b0;
            g_v_reg    <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (acc) begin
                        case (s_data.func)
                            FUNC_CLEAR: stored_reg <= '0;
                            FUNC_LOAD: if (we) stored_reg <= stored_reg + 1'b1;
                            FUNC_QUERY: begin
                                q_reg    <= s_data[65:2];
                                k_reg    <= kc;
                                used_reg <= '0;
                                scan_reg <= '0;
                                rd_v_reg <= 1'b0;
                                state_reg <= ST_SCAN;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_SCAN: begin
                    rd_v_reg <= scan_reg < stored_reg;
                    rd_i_reg <= scan_reg[IDX_W-1:0];
                    if (scan_reg < stored_reg) scan_reg <= scan_reg + 1'b1;
                    if (rd_v_reg && ins) begin
                        for (int j = 0; j < MAX_NEIGHBOURS; j++) begin
                            logic lt_here, lt_prev;
                            lt_here = (K_W'(j) < used_reg) ? (bd_reg[j] > dist_sum) : 1'b1;
                            lt_prev = (j == 0) ? 1'b0
                                               : (bd_reg[(j == 0) ? 0 : j - 1] > dist_sum);
                            if (K_W'(j) < used_next) begin
                                if (j > 0 && lt_prev) begin
                                    bd_reg[j] <= bd_reg[(j == 0) ? 0 : j - 1];
                                    bi_reg[j] <= bi_reg[(j == 0) ? 0 : j - 1];
                                end else if (lt_here) begin
                                    bd_reg[j] <= dist_sum;
                                    bi_reg[j] <= rd_i_reg;
                                end
                            end
                        end
                        used_reg <= used_next;
                    end
                    if (!(scan_reg < stored_reg) && !(rd_v_reg && scan_reg > CNT_W'(rd_i_reg)
                        + 1'b1) && !rd_v_reg) begin
                        state_reg <= ST_GATHER;
                        g_reg     <= '0;
                        g_v_reg   <= 1'b0;
                        for (int a = 0; a < 4; a++) sum_reg[a] <= '0;
                        for (int c = 0; c < 3; c++) cnt_reg[c] <= '0;
                    end
                end
                ST_GATHER: begin
                    g_v_reg <= g_reg < used_reg;
                    if (g_reg < used_reg) g_reg <= g_reg + 1'b1;
                    if (g_v_reg) begin
                        for (int a = 0; a < 4; a++)
                            sum_reg[a] <= sum_reg[a] + SUM_W'(rdata[16*a +: 16]);
                        for (int c = 0; c < 3; c++)
                            if (rdata[65:64] == 2'(c)) cnt_reg[c] <= cnt_reg[c] + 1'b1;
                    end
                    if (!g_v_reg && g_reg == used_reg) begin
                        state_reg <= (used_reg == '0) ? ST_OUT : ST_DIVIDE;
                        if (used_reg == '0) begin
                            m_data  <= '0;
                            m_valid <= 1'b1;
                        end
                    end
                end
                ST_DIVIDE: begin
                    if (div_done) begin
                        m_data.mean_sepal_len   <= quo[0];
                        m_data.mean_sepal_wid   <= quo[1];
                        m_data.mean_petal_len   <= quo[2];
                        m_data.mean_petal_wid   <= quo[3];
                        m_data.count_virginica  <= cnt_reg[0];
                        m_data.count_versicolor <= cnt_reg[1];
                        m_data.count_setosa     <= cnt_reg[2];
                        if (cnt_reg[0] >= cnt_reg[1] && cnt_reg[0] >= cnt_reg[2])
                            m_data.majority_class <= CLASS_VIRGINICA;
                        else if (cnt_reg[1] >= cnt_reg[2])
                            m_data.majority_class <= CLASS_VERSICOLOR;
                        else
                            m_data.majority_class <= CLASS_SETOSA;
                        m_valid   <= 1'b1;
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (m_ready) begin
                        m_valid   <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

/* hdl/knn_manhattan_classifier.sv */
`timescale 1ns / 1ps
// Channel   Direction  Ports                     Payload
// s_        in         s_valid s_ready s_data    knn_in_t (func, attributes, class)
// m_        out        m_valid m_ready m_data    knn_out_t (means, counts, majority)
// cfg       in         cfg_valid cfg_ready cfg_data  K, 6 bits
//
// Clear and load transfers leave the input ready, so they may follow back to back.
// A query scans all N stored samples for the K nearest, sums their attributes and
// counts their classes, then divides the sums by the count of neighbours found.
// On an empty store the scan and gather states find no sample and the all-zero result is presented without a divide.
// Reset is synchronous, active low, empties the store and sets K to 3.
// No s_ transfer is taken while a query runs or its result waits for m_ready.
module knn_manhattan_classifier import knn_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  knn_in_t         s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output knn_out_t        m_data,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [K_W-1:0]  cfg_data
);
    logic [K_W-1:0] k_reg;

    // The register accepts a write in every cycle.
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg <= K_RESET;
        end else if (cfg_valid) begin
            k_reg <= cfg_data;
        end
    end

    knn_engine u_engine (
        .aclk(aclk), .aresetn(aresetn), .k_cfg(k_reg),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );
endmodule

/* hdl/knn_checker.sv */
`timescale 1ns / 1ps
`include "knn_manhattan_classifier_defines.svh"
module knn_checker import knn_pkg::*; (
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input logic     m_valid,
    input logic     m_ready,
    input knn_out_t m_data
);
    // A result never coexists with a free input side.
    `KNN_ASSERT_IMP(a_busy_out, aclk, aresetn, m_valid, !s_ready)
    // A stalled result holds.
    `KNN_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))
    // Counts never exceed the neighbour limit.
    `KNN_ASSERT_IMP(a_cnt, aclk, aresetn, m_valid,
        m_data.count_virginica + m_data.count_versicolor + m_data.count_setosa <= 7'd32)
    // Majority code is one of the three classes.
    `KNN_ASSERT_IMP(a_major, aclk, aresetn, m_valid, m_data.majority_class != CLASS_OTHER)
endmodule

bind knn_manhattan_classifier knn_checker u_knn_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
);
